// ----- hw/rtl/nearest_neighbor_frame_scaler_unit_macros.svh -----
// assertion macros shared by the scaler rtl
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_UNIT_MACROS_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define NNFS_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("scaler implication check failed");

// next-cycle implication, checked out of reset
`define NNFS_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("scaler next-cycle check failed");

`endif

// ----- hw/rtl/nnfs_pkg.sv -----
// types and constants of the frame scaler
`timescale 1ns / 1ps

package nnfs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_FULL_SCREEN   = 3'd4;
  localparam logic [2:0] CFG_ZOOM_PERCENT  = 3'd5;

  // register reset values
  localparam logic [8:0] RST_SRC_WIDTH     = 9'd160;
  localparam logic [7:0] RST_SRC_HEIGHT    = 8'd102;
  localparam logic [8:0] RST_SCREEN_WIDTH  = 9'd240;
  localparam logic [8:0] RST_SCREEN_HEIGHT = 9'd135;
  localparam logic [8:0] RST_ZOOM_PERCENT  = 9'd100;

  // unity zoom and percent scale
  localparam logic [8:0] ZOOM_UNITY = 9'd100;
  localparam logic [6:0] PERCENT    = 7'd100;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // inverse scale width and its saturation value
  localparam int INV_W = 24;
  localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divisor width: window times zoom
  localparam int DEN_W = 19;

  // sequencer states
  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_CMP_A    = 16'h0002,
    ST_CMP_B    = 16'h0004,
    ST_FIT_MUL  = 16'h0008,
    ST_FIT_DIV  = 16'h0010,
    ST_SCX_MUL  = 16'h0020,
    ST_SCX_DIV  = 16'h0040,
    ST_SCY_MUL  = 16'h0080,
    ST_SCY_DIV  = 16'h0100,
    ST_MAPX_MUL = 16'h0200,
    ST_MAPX_ADD = 16'h0400,
    ST_MAPY_MUL = 16'h0800,
    ST_MAPY_ADD = 16'h1000,
    ST_ADDR     = 16'h2000,
    ST_READ     = 16'h4000,
    ST_OUT      = 16'h8000
  } state_t;

  // divider control
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ----- hw/rtl/nnfs_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module nnfs_div #(
  parameter int NUM_W = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [NUM_W-1:0]             num,
  input  logic [nnfs_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [NUM_W-1:0]             quo
);

  localparam int DW  = nnfs_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DW:0]      shifted;
  logic             fits;

  // trial subtract of the next partial remainder
  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (running) begin
      rem <= fits ? DW'(shifted - {1'b0, dvs}) : shifted[DW-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ----- hw/rtl/nearest_neighbor_frame_scaler_unit.sv -----
// top level: frame store, window sequencer and coordinate mapping
// channel   | signals                                      | transfer when
// item in   | start busy mode src_index pixel_in dst_x dst_y | start and not busy
// result    | done pixel_out screen_x screen_y in_window   | done high, one cycle
// config    | cfg_valid cfg_ready cfg_index cfg_data       | cfg_valid and cfg_ready
// a load leaves the block idle; a draw inside the window runs through the shared
// multiplier, one address multiply and a registered frame store read; one outside goes
// straight to the result; the first draw after reset or a config write adds divider
// passes: two in full-screen mode, three after the compare states in letterbox
// reset is synchronous and clears the sequencer, registers and window; the store
// holds no reset; the result receiver cannot stall
`timescale 1ns / 1ps
`include "nearest_neighbor_frame_scaler_unit_macros.svh"

module nearest_neighbor_frame_scaler_unit #(
  parameter int FRAME_PIXELS    = 32768,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [14:0] src_index,
  input  logic [15:0] pixel_in,
  input  logic [8:0]  dst_x,
  input  logic [8:0]  dst_y,
  output logic        done,
  output logic [15:0] pixel_out,
  output logic [9:0]  screen_x,
  output logic [9:0]  screen_y,
  output logic        in_window,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int ADDR_W = $clog2(FRAME_PIXELS);
  localparam int NUM_W  = 15 + SCALE_FRAC_BITS;
  localparam int QX_W   = NUM_W + nnfs_pkg::INV_W;
  localparam int T_W    = nnfs_pkg::PROD_W + 1;
  localparam int IDX_W  = 17;
  localparam int AW     = nnfs_pkg::MUL_A_W;
  localparam int BW     = nnfs_pkg::MUL_B_W;

  nnfs_pkg::state_t state;

  // configuration registers
  logic [8:0] src_width, screen_width, screen_height, zoom_percent;
  logic [7:0] src_height;
  logic       full_screen;

  // window state
  logic [9:0] window_width, window_height;
  logic [8:0] window_x_offset, window_y_offset;
  logic [nnfs_pkg::INV_W-1:0] inverse_scale_x, inverse_scale_y;
  logic       transform_ready;

  // item and work registers
  logic [8:0] dx, dy;
  logic [8:0] sx, sy;
  logic       fit_width;
  logic       hit;
  logic [IDX_W-1:0] idx;
  logic signed [nnfs_pkg::PROD_W-1:0] prod;
  logic [15:0] rd_data;
  logic [15:0] frame_store [FRAME_PIXELS];

  // divider
  nnfs_pkg::div_ctl_t          div_ctl;
  logic                        kick;
  logic [NUM_W-1:0]            div_num;
  logic [nnfs_pkg::DEN_W-1:0]  div_den;
  logic [NUM_W-1:0]            div_quo;
  logic [QX_W-1:0]             quo_x;
  logic [nnfs_pkg::INV_W-1:0]  inv_sat;
  logic [9:0]                  quo_win;

  // effective sizes
  logic [8:0] sw, lw, lh, zoom;
  logic [7:0] sh;
  logic [15:0] src100;

  // shared multiplier
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [nnfs_pkg::PROD_W-1:0] mul_p;

  logic accept;
  logic signed [AW-1:0] delta;
  logic signed [T_W-1:0] t_sum;
  logic [8:0] clamped;
  logic [8:0] map_src;

  assign accept    = start && !busy;
  assign busy      = state != nnfs_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;

  assign sw   = (src_width == 9'd0) ? 9'd1 : src_width;
  assign sh   = (src_height == 8'd0) ? 8'd1 : src_height;
  assign lw   = (screen_width == 9'd0) ? 9'd1 : screen_width;
  assign lh   = (screen_height == 9'd0) ? 9'd1 : screen_height;
  assign zoom = (zoom_percent == 9'd0) ? nnfs_pkg::ZOOM_UNITY : zoom_percent;

  // source size times the percent scale, for the scale numerator
  always_comb begin
    if (state == nnfs_pkg::ST_SCX_MUL) begin
      src100 = 16'(sw * nnfs_pkg::PERCENT);
    end else begin
      src100 = 16'({1'b0, sh} * nnfs_pkg::PERCENT);
    end
  end

  // divider quotient saturation and window size floor of one
  assign quo_x   = QX_W'(div_quo);
  assign inv_sat = (|quo_x[QX_W-1:nnfs_pkg::INV_W]) ? nnfs_pkg::INV_MAX
                                                     : quo_x[nnfs_pkg::INV_W-1:0];
  assign quo_win = (div_quo[9:0] == 10'd0) ? 10'd1 : div_quo[9:0];

  // centred destination offset in half pixels
  always_comb begin
    if (state == nnfs_pkg::ST_MAPX_MUL) begin
      delta = AW'({dx, 1'b0}) - AW'(window_width - 10'd1);
    end else begin
      delta = AW'({dy, 1'b0}) - AW'(window_height - 10'd1);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (state)
      nnfs_pkg::ST_CMP_A: begin
        mul_a = AW'(lw);
        mul_b = BW'(sh);
      end
      nnfs_pkg::ST_CMP_B: begin
        mul_a = AW'(lh);
        mul_b = BW'(sw);
      end
      nnfs_pkg::ST_FIT_MUL: begin
        mul_a = fit_width ? AW'(lw) : AW'(lh);
        mul_b = fit_width ? BW'(sh) : BW'(sw);
      end
      nnfs_pkg::ST_SCX_MUL: begin
        mul_a = AW'(window_width);
        mul_b = BW'(zoom);
      end
      nnfs_pkg::ST_SCY_MUL: begin
        mul_a = AW'(window_height);
        mul_b = BW'(zoom);
      end
      nnfs_pkg::ST_MAPX_MUL: begin
        mul_a = delta;
        mul_b = BW'(inverse_scale_x);
      end
      nnfs_pkg::ST_MAPY_MUL: begin
        mul_a = delta;
        mul_b = BW'(inverse_scale_y);
      end
      nnfs_pkg::ST_ADDR: begin
        mul_a = AW'(sy);
        mul_b = BW'(sw);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // source coordinate: half-pixel sum, truncated and clamped to the frame
  assign map_src = (state == nnfs_pkg::ST_MAPX_ADD) ? sw : {1'b0, sh};
  assign t_sum   = T_W'(prod) + $signed(T_W'(map_src) << SCALE_FRAC_BITS);

  always_comb begin
    logic [T_W-1:0] c;
    c = T_W'(t_sum) >> (SCALE_FRAC_BITS + 1);
    if (t_sum < 0) begin
      clamped = 9'd0;
    end else if (c >= T_W'(map_src)) begin
      clamped = map_src - 9'd1;
    end else begin
      clamped = c[8:0];
    end
  end

  assign div_ctl.start = (state == nnfs_pkg::ST_FIT_DIV || state == nnfs_pkg::ST_SCX_DIV ||
                          state == nnfs_pkg::ST_SCY_DIV) && kick;

  nnfs_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_ctl.start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_ctl.done),
    .quo   (div_quo)
  );

  // sequencer, configuration and window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= nnfs_pkg::ST_IDLE;
      kick            <= 1'b0;
      src_width       <= nnfs_pkg::RST_SRC_WIDTH;
      src_height      <= nnfs_pkg::RST_SRC_HEIGHT;
      screen_width    <= nnfs_pkg::RST_SCREEN_WIDTH;
      screen_height   <= nnfs_pkg::RST_SCREEN_HEIGHT;
      full_screen     <= 1'b1;
      zoom_percent    <= nnfs_pkg::RST_ZOOM_PERCENT;
      window_width    <= '0;
      window_height   <= '0;
      window_x_offset <= '0;
      window_y_offset <= '0;
      inverse_scale_x <= '0;
      inverse_scale_y <= '0;
      transform_ready <= 1'b0;
    end else begin
      kick <= 1'b0;
      // configuration write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nnfs_pkg::CFG_SRC_WIDTH:     src_width     <= cfg_data;
          nnfs_pkg::CFG_SRC_HEIGHT:    src_height    <= cfg_data[7:0];
          nnfs_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          nnfs_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
          nnfs_pkg::CFG_FULL_SCREEN:   full_screen   <= cfg_data[0];
          nnfs_pkg::CFG_ZOOM_PERCENT:  zoom_percent  <= cfg_data;
          default: ;
        endcase
        if (cfg_index inside {[nnfs_pkg::CFG_SRC_WIDTH:nnfs_pkg::CFG_ZOOM_PERCENT]}) begin
          transform_ready <= 1'b0;
        end
      end
      case (state)
        nnfs_pkg::ST_IDLE: begin
          if (accept && mode == nnfs_pkg::MODE_DRAW) begin
            if (transform_ready) begin
              state <= nnfs_pkg::ST_MAPX_MUL;
            end else if (full_screen) begin
              window_width    <= {1'b0, lw};
              window_height   <= {1'b0, lh};
              window_x_offset <= '0;
              window_y_offset <= '0;
              state           <= nnfs_pkg::ST_SCX_MUL;
            end else begin
              state <= nnfs_pkg::ST_CMP_A;
            end
          end
        end
        nnfs_pkg::ST_CMP_A: state <= nnfs_pkg::ST_CMP_B;
        nnfs_pkg::ST_CMP_B: state <= nnfs_pkg::ST_FIT_MUL;
        nnfs_pkg::ST_FIT_MUL: begin
          if (fit_width) begin
            window_width <= {1'b0, lw};
          end else begin
            window_height <= {1'b0, lh};
          end
          kick  <= 1'b1;
          state <= nnfs_pkg::ST_FIT_DIV;
        end
        nnfs_pkg::ST_FIT_DIV: begin
          if (div_ctl.done) begin
            if (fit_width) begin
              window_height <= quo_win;
            end else begin
              window_width <= quo_win;
            end
            state <= nnfs_pkg::ST_SCX_MUL;
          end
        end
        nnfs_pkg::ST_SCX_MUL: begin
          if (!full_screen) begin
            window_x_offset <= 9'(({1'b0, lw} - window_width) >> 1);
            window_y_offset <= 9'(({1'b0, lh} - window_height) >> 1);
          end
          kick  <= 1'b1;
          state <= nnfs_pkg::ST_SCX_DIV;
        end
        nnfs_pkg::ST_SCX_DIV: begin
          if (div_ctl.done) begin
            inverse_scale_x <= inv_sat;
            state           <= nnfs_pkg::ST_SCY_MUL;
          end
        end
        nnfs_pkg::ST_SCY_MUL: begin
          kick  <= 1'b1;
          state <= nnfs_pkg::ST_SCY_DIV;
        end
        nnfs_pkg::ST_SCY_DIV: begin
          if (div_ctl.done) begin
            inverse_scale_y <= inv_sat;
            transform_ready <= 1'b1;
            state           <= nnfs_pkg::ST_MAPX_MUL;
          end
        end
        nnfs_pkg::ST_MAPX_MUL: begin
          if ({1'b0, dx} < window_width && {1'b0, dy} < window_height) begin
            state <= nnfs_pkg::ST_MAPX_ADD;
          end else begin
            state <= nnfs_pkg::ST_OUT;
          end
        end
        nnfs_pkg::ST_MAPX_ADD: state <= nnfs_pkg::ST_MAPY_MUL;
        nnfs_pkg::ST_MAPY_MUL: state <= nnfs_pkg::ST_MAPY_ADD;
        nnfs_pkg::ST_MAPY_ADD: state <= nnfs_pkg::ST_ADDR;
        nnfs_pkg::ST_ADDR:     state <= nnfs_pkg::ST_READ;
        nnfs_pkg::ST_READ:     state <= nnfs_pkg::ST_OUT;
        nnfs_pkg::ST_OUT:      state <= nnfs_pkg::ST_IDLE;
        default:               state <= nnfs_pkg::ST_IDLE;
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      dx <= dst_x;
      dy <= dst_y;
    end
    case (state)
      nnfs_pkg::ST_IDLE: hit <= 1'b0;
      nnfs_pkg::ST_CMP_A: prod <= mul_p;
      nnfs_pkg::ST_CMP_B: fit_width <= prod <= mul_p;
      nnfs_pkg::ST_FIT_MUL: begin
        div_num <= NUM_W'(mul_p);
        div_den <= fit_width ? nnfs_pkg::DEN_W'(sw) : nnfs_pkg::DEN_W'(sh);
      end
      nnfs_pkg::ST_SCX_MUL, nnfs_pkg::ST_SCY_MUL: begin
        div_num <= NUM_W'(src100) << SCALE_FRAC_BITS;
        div_den <= nnfs_pkg::DEN_W'(mul_p);
      end
      nnfs_pkg::ST_MAPX_MUL, nnfs_pkg::ST_MAPY_MUL: prod <= mul_p;
      nnfs_pkg::ST_MAPX_ADD: begin
        sx  <= clamped;
        hit <= 1'b1;
      end
      nnfs_pkg::ST_MAPY_ADD: sy <= clamped;
      nnfs_pkg::ST_ADDR: idx <= IDX_W'(mul_p) + IDX_W'(sx);
      default: ;
    endcase
  end

  // frame store write on a load transfer
  always_ff @(posedge clk) begin
    logic [IDX_W-1:0] wr_idx;
    wr_idx = IDX_W'(src_index);
    if (accept && mode == nnfs_pkg::MODE_LOAD && wr_idx < IDX_W'(FRAME_PIXELS)) begin
      frame_store[wr_idx[ADDR_W-1:0]] <= pixel_in;
    end
  end

  // registered frame store read
  always_ff @(posedge clk) begin
    if (state == nnfs_pkg::ST_READ) begin
      rd_data <= frame_store[idx[ADDR_W-1:0]];
    end
  end

  // result, marked by done in the output state
  assign done      = state == nnfs_pkg::ST_OUT;
  assign in_window = done && hit;
  assign pixel_out = (in_window && idx < IDX_W'(FRAME_PIXELS)) ? rd_data : 16'd0;
  assign screen_x  = 10'(window_x_offset) + 10'(dx);
  assign screen_y  = 10'(window_y_offset) + 10'(dy);

  // checks
  `NNFS_ASSERT_NXT(a_draw_goes_busy, accept && mode == nnfs_pkg::MODE_DRAW, busy)
  `NNFS_ASSERT_NXT(a_done_single, done, !done && !busy)
  `NNFS_ASSERT_IMP(a_div_done_in_wait, div_ctl.done,
    state == nnfs_pkg::ST_FIT_DIV || state == nnfs_pkg::ST_SCX_DIV ||
    state == nnfs_pkg::ST_SCY_DIV)
  `NNFS_ASSERT_IMP(a_map_needs_window, state == nnfs_pkg::ST_MAPX_ADD,
    transform_ready && window_width != 10'd0 && window_height != 10'd0)

endmodule

// ----- tb/sv/nearest_neighbor_frame_scaler_unit_checker.sv -----
// checker: predicts scaler results from observed transfers and compares them
`timescale 1ns / 1ps

module nearest_neighbor_frame_scaler_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [14:0] src_index,
  input  logic [15:0] pixel_in,
  input  logic [8:0]  dst_x,
  input  logic [8:0]  dst_y,
  input  logic        done,
  input  logic [15:0] pixel_out,
  input  logic [9:0]  screen_x,
  input  logic [9:0]  screen_y,
  input  logic        in_window,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          errors,
  output int          pending
);

  localparam int STORE_DEPTH = 32768;
  localparam int FRAC = 16;
  localparam longint SAT = 64'hFFFFFF;

  typedef struct packed {
    logic [15:0] pixel;
    logic [9:0]  sx;
    logic [9:0]  sy;
    logic        in_win;
  } draw_result_t;

  logic [15:0]  pixel_mem [STORE_DEPTH];
  draw_result_t draw_q[$];

  // shadow of the configuration registers
  logic [8:0] reg_sw, reg_lw, reg_lh, reg_zoom;
  logic [7:0] reg_sh;
  logic       reg_fs;

  // shadow of the window
  longint win_w, win_h, off_x, off_y, step_x, step_y;
  bit     win_valid;

  function automatic longint nonzero(longint v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint inverse_step(longint src, longint win, longint zm);
    longint q;
    q = ((src * 100) << FRAC) / (win * zm);
    return (q > SAT) ? SAT : q;
  endfunction

  function automatic longint source_coord(longint d, longint win, longint src,
                                          longint stp);
    longint t, c;
    t = (src << FRAC) + (2 * d - (win - 1)) * stp;
    if (t < 0) return 0;
    c = t >>> (FRAC + 1);
    return (c >= src) ? src - 1 : c;
  endfunction

  task automatic fit_window();
    longint sw, sh, lw, lh, zm, w, h;
    sw = nonzero(reg_sw);
    sh = nonzero(reg_sh);
    lw = nonzero(reg_lw);
    lh = nonzero(reg_lh);
    zm = (reg_zoom == 0) ? 100 : reg_zoom;
    if (reg_fs) begin
      w = lw;
      h = lh;
      off_x = 0;
      off_y = 0;
    end else begin
      if (lw * sh <= lh * sw) begin
        w = lw;
        h = (sh * lw) / sw;
      end else begin
        h = lh;
        w = (sw * lh) / sh;
      end
      w = nonzero(w);
      h = nonzero(h);
      off_x = (lw - w) / 2;
      off_y = (lh - h) / 2;
    end
    win_w = w;
    win_h = h;
    step_x = inverse_step(sw, w, zm);
    step_y = inverse_step(sh, h, zm);
    win_valid = 1;
  endtask

  task automatic predict_draw(input logic [8:0] dx, input logic [8:0] dy);
    draw_result_t r;
    longint sw, sh, cx, cy, idx;
    if (!win_valid) fit_window();
    r = '0;
    if (dx < win_w && dy < win_h) begin
      sw = nonzero(reg_sw);
      sh = nonzero(reg_sh);
      cx = source_coord(dx, win_w, sw, step_x);
      cy = source_coord(dy, win_h, sh, step_y);
      idx = cy * sw + cx;
      if (idx < STORE_DEPTH) r.pixel = pixel_mem[idx];
      r.in_win = 1'b1;
    end
    r.sx = 10'(off_x + dx);
    r.sy = 10'(off_y + dy);
    draw_q.push_back(r);
  endtask

  // observe transfers, predict and compare
  always @(posedge clk) begin
    draw_result_t want;
    if (rst) begin
      reg_sw <= nnfs_pkg::RST_SRC_WIDTH;
      reg_sh <= nnfs_pkg::RST_SRC_HEIGHT;
      reg_lw <= nnfs_pkg::RST_SCREEN_WIDTH;
      reg_lh <= nnfs_pkg::RST_SCREEN_HEIGHT;
      reg_fs <= 1'b1;
      reg_zoom <= nnfs_pkg::RST_ZOOM_PERCENT;
      errors <= 0;
      win_valid = 0;
      draw_q.delete();
      pending = 0;
    end else begin
      // result transfer
      if (done) begin
        if (draw_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result at %0t", $time);
        end else begin
          want = draw_q.pop_front();
          if (want.pixel !== pixel_out || want.sx !== screen_x ||
              want.sy !== screen_y || want.in_win !== in_window) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch at %0t: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                       $time, want.pixel, want.sx, want.sy, want.in_win,
                       pixel_out, screen_x, screen_y, in_window);
          end
        end
      end
      // item transfer
      if (start && !busy) begin
        if (mode == nnfs_pkg::MODE_LOAD) pixel_mem[src_index] = pixel_in;
        else predict_draw(dst_x, dst_y);
      end
      // configuration transfer; indexes off the list are dropped
      if (cfg_valid && cfg_ready && cfg_index <= nnfs_pkg::CFG_ZOOM_PERCENT) begin
        case (cfg_index)
          nnfs_pkg::CFG_SRC_WIDTH:     reg_sw <= cfg_data;
          nnfs_pkg::CFG_SRC_HEIGHT:    reg_sh <= cfg_data[7:0];
          nnfs_pkg::CFG_SCREEN_WIDTH:  reg_lw <= cfg_data;
          nnfs_pkg::CFG_SCREEN_HEIGHT: reg_lh <= cfg_data;
          nnfs_pkg::CFG_FULL_SCREEN:   reg_fs <= cfg_data[0];
          default:                     reg_zoom <= cfg_data;
        endcase
        win_valid = 0;
      end
      pending = draw_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_nearest_neighbor_frame_scaler_unit.sv -----
// testbench top: stimulus, clock, reset, watchdog and verdict for the scaler
`timescale 1ns / 1ps

module tb_nearest_neighbor_frame_scaler_unit;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 150;
  localparam int FILL_PIXELS = 512;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = nnfs_pkg::MODE_LOAD;
  logic [14:0] src_index = '0;
  logic [15:0] pixel_in = '0;
  logic [8:0]  dst_x = '0;
  logic [8:0]  dst_y = '0;
  logic        done;
  logic [15:0] pixel_out;
  logic [9:0]  screen_x, screen_y;
  logic        in_window;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  int          errors, pending;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          cur_lw = 240, cur_lh = 135;

  always #5 clk = ~clk;

  nearest_neighbor_frame_scaler_unit uut (.*);

  nearest_neighbor_frame_scaler_unit_checker chk (.*);

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one item transfer, with bursts and random gaps before it
  task automatic send_item(input logic m, input logic [14:0] idx, input logic [15:0] pix,
                           input logic [8:0] x, input logic [8:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    mode <= m;
    src_index <= idx;
    pixel_in <= pix;
    dst_x <= x;
    dst_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_pixel(input logic [14:0] idx, input logic [15:0] pix);
    send_item(nnfs_pkg::MODE_LOAD, idx, pix, 9'($urandom), 9'($urandom));
  endtask

  task automatic draw_at(input logic [8:0] x, input logic [8:0] y);
    send_item(nnfs_pkg::MODE_DRAW, 15'($urandom), 16'($urandom), x, y);
  endtask

  // mostly on screen, sometimes anywhere in the field
  task automatic draw_random();
    if ($urandom_range(0, 9) < 8)
      draw_at(9'($urandom_range(0, (cur_lw == 0 ? 1 : cur_lw) - 1)),
              9'($urandom_range(0, (cur_lh == 0 ? 1 : cur_lh) - 1)));
    else
      draw_at(9'($urandom), 9'($urandom));
  endtask

  // quiet the block before touching its registers
  task automatic wait_quiet();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_frame(input int sw, input int sh, input int lw, input int lh,
                           input int fs, input int zm);
    wait_quiet();
    write_reg(nnfs_pkg::CFG_SRC_WIDTH, 9'(sw));
    write_reg(nnfs_pkg::CFG_SRC_HEIGHT, 9'(sh));
    write_reg(nnfs_pkg::CFG_SCREEN_WIDTH, 9'(lw));
    write_reg(nnfs_pkg::CFG_SCREEN_HEIGHT, 9'(lh));
    write_reg(nnfs_pkg::CFG_FULL_SCREEN, 9'(fs));
    write_reg(nnfs_pkg::CFG_ZOOM_PERCENT, 9'(zm));
    // index past the register list, ignored by the block
    if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(6, 7)), 9'($urandom));
    cfg_valid <= 1'b0;
    cur_lw = lw;
    cur_lh = lh;
  endtask

  // random frame whose source area stays inside the filled part of the store
  task automatic random_frame();
    int sw;
    int sh_max;
    sw = $urandom_range(0, 256);
    sh_max = FILL_PIXELS / ((sw == 0) ? 1 : sw);
    if (sh_max > 128) sh_max = 128;
    set_frame(sw, $urandom_range(0, sh_max), $urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, 1),
              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                                         : $urandom_range(25, 400));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the low part of the store; the frames set later read only there
    for (int i = 0; i < FILL_PIXELS; i++) load_pixel(15'(i), 16'($urandom));

    // directed: default settings, corners, outside, extreme pixels
    load_pixel(15'd0, 16'h0000);
    load_pixel(15'd32767, 16'hFFFF);
    load_pixel(15'd16319, 16'hFFFF);
    draw_at(9'd0, 9'd0);
    draw_at(9'd239, 9'd134);
    draw_at(9'd240, 9'd0);
    draw_at(9'd0, 9'd135);
    draw_at(9'd511, 9'd511);
    set_frame(256, 2, 511, 511, 0, 400);
    draw_at(9'd0, 9'd0);
    draw_at(9'd510, 9'd2);
    draw_at(9'd255, 9'd3);
    set_frame(4, 128, 511, 511, 0, 400);
    draw_at(9'd14, 9'd510);
    draw_at(9'd15, 9'd0);
    set_frame(1, 1, 1, 1, 1, 1);
    draw_at(9'd0, 9'd0);
    draw_at(9'd1, 9'd0);
    set_frame(0, 0, 0, 0, 0, 0);
    draw_at(9'd0, 9'd0);
    draw_at(9'd511, 9'd0);
    set_frame(256, 1, 3, 511, 0, 511);
    draw_at(9'd1, 9'd255);
    draw_at(9'd2, 9'd0);

    // phases of fixed and random settings with mixed traffic
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_frame(256, 2, 511, 511, 1, 1);
        1: set_frame(1, 128, 511, 1, 0, 100);
        2: set_frame(32, 16, 240, 135, 0, 0);
        default: random_frame();
      endcase
      for (int n = 0; n < 35; n++) begin
        if ($urandom_range(0, 9) < 7) draw_random();
        else load_pixel(15'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                        : $urandom_range(0, 511)),
                        16'($urandom));
      end
    end

    wait_quiet();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
